@@ rtl/vfcm_pkg.sv @@
// Shared types, codes and corner tables for the voxel face cull mesher.
// No dependencies; used by every module under rtl/.
package vfcm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_BLK = 2'd0,
    OP_LOAD_TEX = 2'd1,
    OP_MESH     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] block_index;
    logic [3:0]  block_type;
    logic [23:0] tex;          // side, bottom, top from msb down
  } req_t;

  localparam int ReqW = $bits(req_t);

  localparam int NumFaces = 6;
  localparam int FaceTop = 0;
  localparam int FaceBottom = 5;

  localparam logic [2:0] CORNER_OFFSET [8] = '{
    3'd7, 3'd5, 3'd4, 3'd6, 3'd3, 3'd1, 3'd0, 3'd2
  };

  localparam logic [2:0] FACE_CORNERS [6][6] = '{
    '{3'd0, 3'd4, 3'd7, 3'd0, 3'd7, 3'd3},
    '{3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd7},
    '{3'd7, 3'd6, 3'd2, 3'd7, 3'd2, 3'd3},
    '{3'd0, 3'd1, 3'd5, 3'd0, 3'd5, 3'd4},
    '{3'd3, 3'd2, 3'd1, 3'd3, 3'd1, 3'd0},
    '{3'd2, 3'd6, 3'd5, 3'd2, 3'd5, 3'd1}
  };

  localparam logic [1:0] CORNER_CODE [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

  // Offset bits: 0 = dx, 1 = dy, 2 = dz.
  function automatic logic [2:0] corner_off(input logic [2:0] face, input logic [2:0] k);
    logic [2:0] c;
    c = FACE_CORNERS[face][k];
    return CORNER_OFFSET[c];
  endfunction

endpackage

@@ rtl/voxel_face_cull_mesher_unit.sv @@
// Top level of the voxel face cull mesher: front end, request queue, back end.
// Depends on vfcm_pkg, vfcm_front, vfcm_queue, vfcm_back.
//
// channel   dir  tdata                                           tuser  tlast
// s_axis    in   block_index, block_type, tex_top/bottom/side    cmd    -
// m_axis    out  vertex_word                                     -      last
//
// A load is written into its store as the back end takes it from the queue. A
// mesh request leaves the queue, then passes the coordinate split (reciprocal
// multiplies), the seven block store reads (one read port) and the texture
// read, then emits its vertex words, stepping over each culled face ahead of
// the last open face: up to 36 words. An m_axis stall holds the emitter.
// Reset clears control state only; the stores stay undefined until written.
// The queue lets the front keep accepting while the back end waits on
// m_axis_tready.
module voxel_face_cull_mesher_unit #(
  parameter int SIDE = 16,
  parameter int HEIGHT = 256,
  parameter int NUM_TYPES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // block_index, block_type, tex_top, tex_bottom, tex_side
  input  logic [1:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // vertex_word
  output logic        m_axis_tlast
);

  logic           push;
  vfcm_pkg::req_t push_req;
  logic           q_full;
  logic           q_empty;
  logic           pop;
  vfcm_pkg::req_t head;

  vfcm_front #(
    .ChunkTotal(SIDE * SIDE * HEIGHT),
    .NumTypes(NUM_TYPES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_cmd(s_axis_tuser),
    .in_data(s_axis_tdata),
    .push(push),
    .push_req(push_req),
    .q_full(q_full)
  );

  vfcm_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_req(push_req),
    .full(q_full),
    .pop(pop),
    .empty(q_empty),
    .head(head)
  );

  vfcm_back #(
    .Side(SIDE),
    .Height(HEIGHT),
    .NumTypes(NUM_TYPES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .head(head),
    .pop(pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_word(m_axis_tdata),
    .out_last(m_axis_tlast)
  );

endmodule

@@ rtl/vfcm_front.sv @@
// Front end: accepts stream requests, drops unused or out-of-range ones,
// packs the rest as requests for the queue. Depends on vfcm_pkg.
module vfcm_front #(
  parameter int ChunkTotal = 65536,
  parameter int NumTypes = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [47:0]          in_data,
  output logic                 push,
  output vfcm_pkg::req_t       push_req,
  input  logic                 q_full
);

  logic        keep;
  logic [16:0] idx_ext;
  logic [8:0]  type_ext;
  logic        seen;

  assign in_ready = !q_full;
  assign idx_ext = {1'b0, in_data[15:0]};
  assign type_ext = {5'b0, in_data[19:16]};

  always_comb begin
    unique case (vfcm_pkg::op_t'(in_cmd))
      vfcm_pkg::OP_LOAD_BLK: keep = (32'(idx_ext) < 32'(ChunkTotal));
      vfcm_pkg::OP_MESH:     keep = (32'(idx_ext) < 32'(ChunkTotal));
      vfcm_pkg::OP_LOAD_TEX: keep = (32'(type_ext) < 32'(NumTypes));
      default:               keep = 1'b0;
    endcase
  end

  assign push = in_valid && in_ready && keep;
  assign push_req.op = vfcm_pkg::op_t'(in_cmd);
  assign push_req.block_index = in_data[15:0];
  assign push_req.block_type = in_data[19:16];
  assign push_req.tex = {in_data[43:36], in_data[35:28], in_data[27:20]};

  // track that traffic has passed since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (in_valid && in_ready) begin
      seen <= 1'b1;
    end
  end

  ap_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full) else $error("push into full queue");
  ap_seen_sticky: assert property (@(posedge clk) disable iff (rst)
    seen |=> seen) else $error("seen flag dropped");
  ap_push_kind: assert property (@(posedge clk) disable iff (rst)
    push |-> push_req.op != vfcm_pkg::OP_NONE) else $error("unused command queued");

endmodule

@@ rtl/vfcm_queue.sv @@
// Two-entry request queue between front and back end.
// Depends on vfcm_pkg for the request type.
module vfcm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vfcm_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output vfcm_pkg::req_t head
);

  vfcm_pkg::req_t slot [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  ap_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  ap_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !full) else $error("push into full queue");
  ap_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");

endmodule

@@ rtl/vfcm_back.sv @@
// Back end: block store and texture table, coordinate split, neighbor
// reads and vertex word emission. Depends on vfcm_pkg.
module vfcm_back #(
  parameter int Side = 16,
  parameter int Height = 256,
  parameter int NumTypes = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  vfcm_pkg::req_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_word,
  output logic           out_last
);

  localparam int SH = Side * Height;
  localparam int Total = Side * Side * Height;
  localparam int MemDepth = (Total > 65536) ? 65536 : Total;
  localparam int AW = $clog2(MemDepth);
  localparam int TexDepth = (NumTypes > 16) ? 16 : NumTypes;
  localparam int TW = (TexDepth > 1) ? $clog2(TexDepth) : 1;
  localparam int ShA = 16 + $clog2(SH);
  localparam int ShB = 16 + $clog2(Side);
  localparam longint RecipAL = ((longint'(1) << ShA) + longint'(SH) - 1) / longint'(SH);
  localparam longint RecipBL = ((longint'(1) << ShB) + longint'(Side) - 1) / longint'(Side);
  localparam logic [17:0] RecipA = 18'(RecipAL);
  localparam logic [17:0] RecipB = 18'(RecipBL);
  localparam logic [15:0] StepS = 16'(Side);
  localparam logic [15:0] StepSH = 16'(SH);
  localparam logic [4:0] SideM1 = 5'(Side - 1);
  localparam logic [8:0] HeightM1 = 9'(Height - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_READ = 5'b00100,
    ST_TEX  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t      state;
  logic [3:0]  blk_mem [MemDepth];
  logic [23:0] tex_mem [TexDepth];
  logic [3:0]  rd_data;
  logic [23:0] tex_rd;
  logic [15:0] idx;
  logic [15:0] rem;
  logic [1:0]  step;
  logic [33:0] prod_x;
  logic [20:0] prod_xs;
  logic [33:0] prod_y;
  logic [20:0] prod_ys;
  logic [4:0]  x;
  logic [8:0]  y;
  logic [4:0]  z;
  logic [2:0]  rcnt;
  logic [15:0] rd_addr;
  logic [3:0]  btype;
  logic        tex_ok;
  logic [5:0]  solid;
  logic [5:0]  inb;
  logic [5:0]  empty_f;
  logic [2:0]  face;
  logic [2:0]  k;
  logic        out_free;
  logic        emit;
  logic [2:0]  off;
  logic [7:0]  tex;
  logic        word_last;
  logic [5:0]  rest;

  assign out_free = !out_valid || out_ready;
  assign pop = (state == ST_IDLE) && !q_empty;
  assign emit = (state == ST_EMIT) && empty_f[face] && out_free;

  // store writes
  always_ff @(posedge clk) begin
    if (pop && head.op == vfcm_pkg::OP_LOAD_BLK) begin
      blk_mem[head.block_index[AW-1:0]] <= head.block_type;
    end
    if (pop && head.op == vfcm_pkg::OP_LOAD_TEX) begin
      tex_mem[head.block_type[TW-1:0]] <= head.tex;
    end
  end

  always_comb begin
    case (rcnt)
      3'd1:    rd_addr = idx + StepS;
      3'd2:    rd_addr = idx - 16'd1;
      3'd3:    rd_addr = idx - StepSH;
      3'd4:    rd_addr = idx + StepSH;
      3'd5:    rd_addr = idx + 16'd1;
      3'd6:    rd_addr = idx - StepS;
      default: rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_data <= blk_mem[rd_addr[AW-1:0]];
    end
    if (state == ST_TEX) begin
      tex_rd <= tex_mem[btype[TW-1:0]];
    end
  end

  assign inb[0] = (y != HeightM1);
  assign inb[1] = (z != 5'd0);
  assign inb[2] = (x != 5'd0);
  assign inb[3] = (x != SideM1);
  assign inb[4] = (z != SideM1);
  assign inb[5] = (y != 9'd0);
  assign empty_f = ~(inb & solid);

  // split the index by reciprocal multiplication, one product per cycle
  assign prod_x = 34'(idx) * 34'(RecipA);
  assign prod_xs = 21'(x) * 21'(StepSH);
  assign prod_y = 34'(rem) * 34'(RecipB);
  assign prod_ys = 21'(y) * 21'(StepS);

  assign off = vfcm_pkg::corner_off(face, k);
  always_comb begin
    if (!tex_ok) tex = 8'd0;
    else if (face == 3'(vfcm_pkg::FaceTop)) tex = tex_rd[7:0];
    else if (face == 3'(vfcm_pkg::FaceBottom)) tex = tex_rd[15:8];
    else tex = tex_rd[23:16];
  end
  assign rest = empty_f >> (face + 3'd1);
  assign word_last = (k == 3'd5) && (rest == 6'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop && head.op == vfcm_pkg::OP_MESH) begin
            idx <= head.block_index;
            step <= 2'd0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          step <= step + 2'd1;
          if (step == 2'd0) x <= 5'(prod_x >> ShA);
          if (step == 2'd1) rem <= idx - prod_xs[15:0];
          if (step == 2'd2) y <= 9'(prod_y >> ShB);
          if (step == 2'd3) begin
            z <= 5'(rem - prod_ys[15:0]);
            rcnt <= 3'd0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          rcnt <= rcnt + 3'd1;
          if (rcnt == 3'd1) btype <= rd_data;
          if (rcnt >= 3'd2) solid[rcnt - 3'd2] <= (rd_data != 4'd0);
          if (rcnt == 3'd7) state <= ST_TEX;
        end
        ST_TEX: begin
          tex_ok <= (32'(btype) < 32'(TexDepth));
          face <= 3'd0;
          k <= 3'd0;
          state <= (btype == 4'd0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (!empty_f[face]) begin
            face <= face + 3'd1;
            if (face == 3'd5) state <= ST_IDLE;
          end else if (out_free) begin
            out_word <= {tex, vfcm_pkg::CORNER_CODE[k], face,
                         z + 5'(off[2]), y + 9'(off[1]), x + 5'(off[0])};
            out_last <= word_last;
            if (k == 3'd5) begin
              k <= 3'd0;
              face <= face + 3'd1;
              if (word_last) state <= ST_IDLE;
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ap_load_in_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT) else $error("word outside emit");
  ap_face_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> face <= 3'd5) else $error("face index past bottom");
  ap_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE) else $error("request taken while busy");

endmodule
